>>> rtl/core/pngu_pkg.sv
package pngu_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int PX_BYTES        = 4;
    localparam int ROW_BYTES       = MAX_WIDTH * PX_BYTES;
    localparam int COL_W           = $clog2(ROW_BYTES);
    localparam int STRIDE_W        = COL_W + 1;
    localparam int CH_W            = $clog2(PX_BYTES);
    localparam int WIDTH_W         = 11;
    localparam int HEIGHT_W        = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PIXELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_ROWS  = 1'b1;

    localparam logic [7:0] FILTER_TYPE_MAX = 8'd4;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4,
        FILT_BAD   = 3'd5
    } filter_t;

    // item held while the prior-row read is in flight
    typedef struct packed {
        logic                 is_filter;
        logic [7:0]           fb;
        logic [COL_W-1:0]     col;
        logic [CH_W-1:0]      ch;
        logic                 has_above;
        filter_t              filt;
        logic                 end_img;
    } stage_item_t;

endpackage

>>> rtl/core/pngu_predict.sv
module pngu_predict (
    input  logic [7:0]        fb,
    input  logic [7:0]        a,
    input  logic [7:0]        b,
    input  logic [7:0]        c,
    input  logic [7:0]        last_recon,
    input  pngu_pkg::filter_t filt,
    output logic [7:0]        x
);

    logic [7:0] pa;
    logic [7:0] pb;
    logic [9:0] ab;
    logic [9:0] c2;
    logic [9:0] pc;
    logic [7:0] paeth;
    logic [8:0] avg_sum;

    always_comb begin
        pa      = (b >= c) ? (b - c) : (c - b);
        pb      = (a >= c) ? (a - c) : (c - a);
        ab      = {2'b00, a} + {2'b00, b};
        c2      = {1'b0, c, 1'b0};
        pc      = (ab >= c2) ? (ab - c2) : (c2 - ab);
        avg_sum = {1'b0, a} + {1'b0, b};
        if ({2'b00, pa} <= {2'b00, pb} && {2'b00, pa} <= pc) begin
            paeth = a;
        end else if ({2'b00, pb} <= pc) begin
            paeth = b;
        end else begin
            paeth = c;
        end
    end

    always_comb begin
        case (filt)
            pngu_pkg::FILT_NONE:  x = fb;
            pngu_pkg::FILT_SUB:   x = fb + a;
            pngu_pkg::FILT_UP:    x = fb + b;
            pngu_pkg::FILT_AVG:   x = fb + avg_sum[8:1];
            pngu_pkg::FILT_PAETH: x = fb + paeth;
            default:              x = last_recon;
        endcase
    end

endmodule

>>> rtl/core/png_scanline_unfilter_unit.sv
// PNG scanline reconstruction for 8-bit RGBA. Bytes of the inflated stream
// enter one per cycle on s_ while s_tready is high; the first byte of every
// row is the filter type and produces no output, every other byte produces
// one reconstructed sample on m_. A byte is registered in the reconstruct
// stage, its sample in the output register once free. The sustained rate is
// one byte per clock while m_tready is high: the accept stage reads the byte
// above from the prior-row memory, the next stage reconstructs the sample and
// writes it back into the same entry, so the memory sees one read and one
// write per cycle. The output register lets a new byte enter while a finished
// sample waits. The prior-row memory needs no clearing after reset; the first
// row of an image takes the byte above as zero. The user must write width
// and height only while no byte is in flight; the block does not check it.
module png_scanline_unfilter_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [pngu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // filtered_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // pixel_byte
    output logic [2:0]                           m_tuser,   // bad_filter, channel[1:0]
    output logic                                 m_tlast    // last_of_image
);

    localparam int COL_W    = pngu_pkg::COL_W;
    localparam int STRIDE_W = pngu_pkg::STRIDE_W;
    localparam int CH_W     = pngu_pkg::CH_W;
    localparam int WIDTH_W  = pngu_pkg::WIDTH_W;
    localparam int HEIGHT_W = pngu_pkg::HEIGHT_W;
    localparam int BPP      = pngu_pkg::PX_BYTES;

    // configuration
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                pngu_pkg::REG_WIDTH_PIXELS: width_reg  <= cfg_wdata[WIDTH_W-1:0];
                pngu_pkg::REG_HEIGHT_ROWS:  height_reg <= cfg_wdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // accept stage: row position
    logic                  expect_filter_reg;
    logic [COL_W-1:0]      byte_column_reg;
    logic [HEIGHT_W-1:0]   row_index_reg;
    pngu_pkg::filter_t     row_filter_reg;

    logic [WIDTH_W-1:0]    w_eff;
    logic [HEIGHT_W-1:0]   h_eff;
    logic [STRIDE_W-1:0]   stride;
    logic [COL_W-1:0]      col;
    logic [STRIDE_W-1:0]   col_inc;
    logic                  end_row;
    logic                  end_img;
    logic [HEIGHT_W:0]     row_inc;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (int'(width_reg) > pngu_pkg::MAX_WIDTH) begin
            w_eff = WIDTH_W'(pngu_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff  = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
        stride = STRIDE_W'(w_eff) * STRIDE_W'(BPP);
        // a column past the row end (width lowered mid-image) sticks at the end
        if ({1'b0, byte_column_reg} >= stride) begin
            col = COL_W'(stride - STRIDE_W'(1));
        end else begin
            col = byte_column_reg;
        end
        col_inc = {1'b0, col} + STRIDE_W'(1);
        row_inc = {1'b0, row_index_reg} + (HEIGHT_W+1)'(1);
        end_row = (col_inc >= stride);
        end_img = end_row && (row_inc >= {1'b0, h_eff});
    end

    // reconstruct stage
    logic                  st_valid_reg;
    pngu_pkg::stage_item_t st_reg;
    logic                  st_fire;
    logic                  s_accept;
    logic                  out_load;

    logic                  m_valid_reg;
    logic [7:0]            m_data_reg;
    logic [2:0]            m_user_reg;
    logic                  m_last_reg;

    assign out_load = st_valid_reg && !st_reg.is_filter && (!m_valid_reg || m_tready);
    assign st_fire  = st_valid_reg && (st_reg.is_filter || !m_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || st_fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_filter_reg <= 1'b1;
            byte_column_reg   <= '0;
            row_index_reg     <= '0;
            row_filter_reg    <= pngu_pkg::FILT_NONE;
        end else if (s_accept) begin
            if (expect_filter_reg) begin
                row_filter_reg    <= (s_tdata > pngu_pkg::FILTER_TYPE_MAX) ?
                                     pngu_pkg::FILT_BAD : pngu_pkg::filter_t'(s_tdata[2:0]);
                byte_column_reg   <= '0;
                expect_filter_reg <= 1'b0;
            end else if (end_row) begin
                expect_filter_reg <= 1'b1;
                byte_column_reg   <= '0;
                row_index_reg     <= end_img ? '0 : row_inc[HEIGHT_W-1:0];
            end else begin
                byte_column_reg   <= col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_accept) begin
            st_valid_reg <= 1'b1;
        end else if (st_fire) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st_reg.is_filter <= expect_filter_reg;
            st_reg.fb        <= s_tdata;
            st_reg.col       <= col;
            st_reg.ch        <= col[CH_W-1:0];
            st_reg.has_above <= (row_index_reg != '0);
            st_reg.filt      <= row_filter_reg;
            st_reg.end_img   <= end_img;
        end
    end

    // prior-row memory; read data holds while the stage waits
    logic [7:0] prior_mem [pngu_pkg::ROW_BYTES];
    logic [7:0] above_rd_reg;
    logic [7:0] recon;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            above_rd_reg <= prior_mem[col];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            prior_mem[st_reg.col] <= recon;
        end
    end

    // per-channel neighbours
    logic [7:0] left_reg  [BPP];
    logic [7:0] upl_reg   [BPP];
    logic [7:0] last_recon_reg;
    logic [7:0] above;

    assign above = st_reg.has_above ? above_rd_reg : 8'd0;

    pngu_predict u_predict (
        .fb         (st_reg.fb),
        .a          (left_reg[st_reg.ch]),
        .b          (above),
        .c          (upl_reg[st_reg.ch]),
        .last_recon (last_recon_reg),
        .filt       (st_reg.filt),
        .x          (recon)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BPP; i++) begin
                left_reg[i] <= '0;
                upl_reg[i]  <= '0;
            end
            last_recon_reg <= '0;
        end else if (st_fire && st_reg.is_filter) begin
            for (int i = 0; i < BPP; i++) begin
                left_reg[i] <= '0;
                upl_reg[i]  <= '0;
            end
            last_recon_reg <= '0;
        end else if (out_load) begin
            left_reg[st_reg.ch] <= recon;
            upl_reg[st_reg.ch]  <= above;
            last_recon_reg      <= recon;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= recon;
            m_user_reg <= {(st_reg.filt == pngu_pkg::FILT_BAD), st_reg.ch};
            m_last_reg <= st_reg.end_img;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // checks
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_image_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !expect_filter_reg && end_img) |=>
            (expect_filter_reg && row_index_reg == '0 && byte_column_reg == '0))
        else $error("end of image did not return to a new filter byte");

    a_row_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_fire && st_reg.is_filter) |=>
            (last_recon_reg == '0 && left_reg[0] == '0 && upl_reg[3] == '0))
        else $error("neighbours not cleared at row start");

endmodule
